/* rtl/core/rac_pkg.sv */
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types and constants of the RGBA alpha compositor pipeline.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int CH_W        = 8;
  localparam int PROD_W      = 2 * CH_W;
  localparam int DEN_W       = 16;
  localparam int NUM_W       = 24;
  localparam int PIX_N       = 4;
  localparam int COLOR_N     = 3;
  localparam int DIV_STEPS   = CH_W;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 23;

  localparam logic [CH_W-1:0]   CH_MAX    = 8'd255;
  // ceil(2^23 / 255): exact x/255 for every x below 2^16
  localparam logic [PROD_W-1:0] RECIP_255 = 16'd32897;

  typedef enum logic [1:0] {
    MODE_PREMUL         = 2'd0,
    MODE_STRAIGHT       = 2'd1,
    MODE_REPLACE        = 2'd2,
    MODE_REPLACE_OPAQUE = 2'd3
  } blend_mode_e;

  typedef logic [CH_W-1:0]   ch_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]  den_t;

  // lane 0 is alpha, lanes 1..3 are red, green, blue
  typedef ch_t [PIX_N-1:0] pix_t;

  // result parts that bypass the divider
  typedef struct packed {
    blend_mode_e mode;
    pix_t        pre;
    ch_t         alpha;
    logic        den_zero;
  } side_t;

endpackage

/* rtl/core/rac_mul_front.sv */
// ----------------------------------------------------------------------------
// rac_mul_front
// Three register stages: channel products, reciprocal scaling and weighted
// sums. Produces the straight-over numerators and coverage for the divider
// and the finished result of every other blend.
// ----------------------------------------------------------------------------
module rac_mul_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  rac_pkg::blend_mode_e                   mode_i,
  input  rac_pkg::pix_t                          front_i,
  input  rac_pkg::pix_t                          back_i,
  output logic                                   valid_o,
  output rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   num_o,
  output rac_pkg::den_t                          den_o,
  output rac_pkg::side_t                         side_o
);

  // stage 1: plain 8x8 products
  rac_pkg::ch_t                            inv0;
  rac_pkg::prod_t [rac_pkg::PIX_N-1:0]     bprod0;
  rac_pkg::prod_t [rac_pkg::COLOR_N-1:0]   fcfa0;
  rac_pkg::prod_t [rac_pkg::COLOR_N-1:0]   bcba0;

  logic                                    s1_vld_q;
  rac_pkg::blend_mode_e                    s1_mode_q;
  rac_pkg::pix_t                           s1_front_q;
  rac_pkg::pix_t                           s1_back_q;
  rac_pkg::ch_t                            s1_inv_q;
  rac_pkg::prod_t [rac_pkg::PIX_N-1:0]     s1_bprod_q;
  rac_pkg::prod_t [rac_pkg::COLOR_N-1:0]   s1_fcfa_q;
  rac_pkg::prod_t [rac_pkg::COLOR_N-1:0]   s1_bcba_q;

  // stage 2: divide by 255 via reciprocal, coverage, numerator terms
  logic [rac_pkg::RECIP_W-1:0]             pq1 [rac_pkg::PIX_N];
  rac_pkg::den_t                           den1;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    fterm1;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    bterm1;

  logic                                    s2_vld_q;
  rac_pkg::blend_mode_e                    s2_mode_q;
  rac_pkg::pix_t                           s2_front_q;
  rac_pkg::pix_t                           s2_back_q;
  rac_pkg::pix_t                           s2_pq_q;
  rac_pkg::den_t                           s2_den_q;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    s2_fterm_q;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    s2_bterm_q;

  // stage 3: sums, straight alpha and the non-divided results
  logic [rac_pkg::RECIP_W-1:0]             ap2;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    num2;
  rac_pkg::side_t                          side2;
  logic [rac_pkg::CH_W:0]                  sum2;

  logic                                    s3_vld_q;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]    s3_num_q;
  rac_pkg::den_t                           s3_den_q;
  rac_pkg::side_t                          s3_side_q;

  always_comb begin
    inv0 = rac_pkg::CH_MAX - front_i[0];
    for (int k = 0; k < rac_pkg::PIX_N; k++) begin
      bprod0[k] = rac_pkg::PROD_W'(back_i[k]) * rac_pkg::PROD_W'(inv0);
    end
    for (int c = 0; c < rac_pkg::COLOR_N; c++) begin
      fcfa0[c] = rac_pkg::PROD_W'(front_i[c+1]) * rac_pkg::PROD_W'(front_i[0]);
      bcba0[c] = rac_pkg::PROD_W'(back_i[c+1]) * rac_pkg::PROD_W'(back_i[0]);
    end
  end

  always_comb begin
    for (int k = 0; k < rac_pkg::PIX_N; k++) begin
      pq1[k] = rac_pkg::RECIP_W'(s1_bprod_q[k]) * rac_pkg::RECIP_W'(rac_pkg::RECIP_255);
    end
    // fa*255 + ba*(255-fa), never above 65025
    den1 = ({s1_front_q[0], 8'd0} - {8'd0, s1_front_q[0]}) + s1_bprod_q[0];
    for (int c = 0; c < rac_pkg::COLOR_N; c++) begin
      fterm1[c] = {s1_fcfa_q[c], 8'd0} - rac_pkg::NUM_W'(s1_fcfa_q[c]);
      bterm1[c] = rac_pkg::NUM_W'(s1_bcba_q[c]) * rac_pkg::NUM_W'(s1_inv_q);
    end
  end

  always_comb begin
    ap2 = rac_pkg::RECIP_W'(s2_den_q) * rac_pkg::RECIP_W'(rac_pkg::RECIP_255);
    sum2 = '0;
    for (int c = 0; c < rac_pkg::COLOR_N; c++) begin
      num2[c] = s2_fterm_q[c] + s2_bterm_q[c];
    end
    side2.mode     = s2_mode_q;
    side2.alpha    = ap2[rac_pkg::RECIP_SHIFT+rac_pkg::CH_W-1:rac_pkg::RECIP_SHIFT];
    side2.den_zero = (s2_den_q == '0);
    side2.pre      = s2_front_q;
    case (s2_mode_q)
      rac_pkg::MODE_PREMUL: begin
        for (int k = 0; k < rac_pkg::PIX_N; k++) begin
          sum2 = {1'b0, s2_front_q[k]} + {1'b0, s2_pq_q[k]};
          side2.pre[k] = sum2[rac_pkg::CH_W] ? rac_pkg::CH_MAX : sum2[rac_pkg::CH_W-1:0];
        end
      end
      rac_pkg::MODE_REPLACE_OPAQUE: begin
        // fall back to the background where the overlay is fully transparent
        side2.pre = (s2_front_q[0] != '0) ? s2_front_q : s2_back_q;
      end
      default: begin
        side2.pre = s2_front_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q  <= mode_i;
    s1_front_q <= front_i;
    s1_back_q  <= back_i;
    s1_inv_q   <= inv0;
    s1_bprod_q <= bprod0;
    s1_fcfa_q  <= fcfa0;
    s1_bcba_q  <= bcba0;

    s2_mode_q  <= s1_mode_q;
    s2_front_q <= s1_front_q;
    s2_back_q  <= s1_back_q;
    for (int k = 0; k < rac_pkg::PIX_N; k++) begin
      s2_pq_q[k] <= pq1[k][rac_pkg::RECIP_SHIFT+rac_pkg::CH_W-1:rac_pkg::RECIP_SHIFT];
    end
    s2_den_q   <= den1;
    s2_fterm_q <= fterm1;
    s2_bterm_q <= bterm1;

    s3_num_q  <= num2;
    s3_den_q  <= s2_den_q;
    s3_side_q <= side2;
  end

  assign valid_o = s3_vld_q;
  assign num_o   = s3_num_q;
  assign den_o   = s3_den_q;
  assign side_o  = s3_side_q;

endmodule

/* rtl/core/rac_div_pipe.sv */
// ----------------------------------------------------------------------------
// rac_div_pipe
// Pipelined restoring divider, one quotient bit per stage, three color lanes
// sharing one divisor. The numerator is below 256 times the divisor, so the
// quotient always fits in one channel.
// ----------------------------------------------------------------------------
module rac_div_pipe (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   num_i,
  input  rac_pkg::den_t                          den_i,
  input  rac_pkg::side_t                         side_i,
  output logic                                   valid_o,
  output rac_pkg::ch_t [rac_pkg::COLOR_N-1:0]    quo_o,
  output rac_pkg::side_t                         side_o
);

  logic [rac_pkg::DIV_STEPS-1:0]          vld_q;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   rem_q  [rac_pkg::DIV_STEPS];
  rac_pkg::ch_t  [rac_pkg::COLOR_N-1:0]   quo_q  [rac_pkg::DIV_STEPS];
  rac_pkg::den_t                          den_q  [rac_pkg::DIV_STEPS];
  rac_pkg::side_t                         side_q [rac_pkg::DIV_STEPS];

  logic [rac_pkg::DIV_STEPS-1:0]          vld_src;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   rem_src  [rac_pkg::DIV_STEPS];
  rac_pkg::ch_t  [rac_pkg::COLOR_N-1:0]   quo_src  [rac_pkg::DIV_STEPS];
  rac_pkg::den_t                          den_src  [rac_pkg::DIV_STEPS];
  rac_pkg::side_t                         side_src [rac_pkg::DIV_STEPS];

  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   rem_d [rac_pkg::DIV_STEPS];
  rac_pkg::ch_t  [rac_pkg::COLOR_N-1:0]   quo_d [rac_pkg::DIV_STEPS];

  always_comb begin
    vld_src[0]  = valid_i;
    rem_src[0]  = num_i;
    quo_src[0]  = '0;
    den_src[0]  = den_i;
    side_src[0] = side_i;
    for (int s = 1; s < rac_pkg::DIV_STEPS; s++) begin
      vld_src[s]  = vld_q[s-1];
      rem_src[s]  = rem_q[s-1];
      quo_src[s]  = quo_q[s-1];
      den_src[s]  = den_q[s-1];
      side_src[s] = side_q[s-1];
    end
  end

  // one trial subtraction per stage, most significant quotient bit first
  always_comb begin
    rac_pkg::num_t trial;
    for (int s = 0; s < rac_pkg::DIV_STEPS; s++) begin
      trial = rac_pkg::NUM_W'(den_src[s]) << (rac_pkg::DIV_STEPS - 1 - s);
      for (int c = 0; c < rac_pkg::COLOR_N; c++) begin
        if (rem_src[s][c] >= trial) begin
          rem_d[s][c] = rem_src[s][c] - trial;
          quo_d[s][c] = {quo_src[s][c][rac_pkg::CH_W-2:0], 1'b1};
        end else begin
          rem_d[s][c] = rem_src[s][c];
          quo_d[s][c] = {quo_src[s][c][rac_pkg::CH_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_src;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < rac_pkg::DIV_STEPS; s++) begin
      rem_q[s]  <= rem_d[s];
      quo_q[s]  <= quo_d[s];
      den_q[s]  <= den_src[s];
      side_q[s] <= side_src[s];
    end
  end

  assign valid_o = vld_q[rac_pkg::DIV_STEPS-1];
  assign quo_o   = quo_q[rac_pkg::DIV_STEPS-1];
  assign side_o  = side_q[rac_pkg::DIV_STEPS-1];

endmodule

/* rtl/core/rgba_alpha_compositor.sv */
// ----------------------------------------------------------------------------
// rgba_alpha_compositor
// Throughput one pixel per cycle; each pixel passes the 3-stage multiply
// front end, the 8-stage divider and the output register.
// busy is always low; the output strobe cannot be held off.
// Reset clears all valid bits and selects premultiplied over.
// ----------------------------------------------------------------------------
module rgba_alpha_compositor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] back_a_i,
  input  logic [7:0] back_r_i,
  input  logic [7:0] back_g_i,
  input  logic [7:0] back_b_i,
  input  logic [7:0] front_a_i,
  input  logic [7:0] front_r_i,
  input  logic [7:0] front_g_i,
  input  logic [7:0] front_b_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  output logic       out_valid_o,
  output logic [7:0] out_a_o,
  output logic [7:0] out_r_o,
  output logic [7:0] out_g_o,
  output logic [7:0] out_b_o
);

  rac_pkg::blend_mode_e                   blend_mode_q;
  rac_pkg::pix_t                          front;
  rac_pkg::pix_t                          back;
  logic                                   accept;

  logic                                   fe_vld;
  rac_pkg::num_t [rac_pkg::COLOR_N-1:0]   fe_num;
  rac_pkg::den_t                          fe_den;
  rac_pkg::side_t                         fe_side;

  logic                                   dv_vld;
  rac_pkg::ch_t  [rac_pkg::COLOR_N-1:0]   dv_quo;
  rac_pkg::side_t                         dv_side;

  rac_pkg::pix_t                          out_d;
  rac_pkg::pix_t                          out_q;
  logic                                   out_valid_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  assign front = {front_b_i, front_g_i, front_r_i, front_a_i};
  assign back  = {back_b_i, back_g_i, back_r_i, back_a_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= rac_pkg::MODE_PREMUL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      blend_mode_q <= rac_pkg::blend_mode_e'(cfg_data_i);
    end
  end

  rac_mul_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .mode_i  (blend_mode_q),
    .front_i (front),
    .back_i  (back),
    .valid_o (fe_vld),
    .num_o   (fe_num),
    .den_o   (fe_den),
    .side_o  (fe_side)
  );

  rac_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_vld),
    .num_i   (fe_num),
    .den_i   (fe_den),
    .side_i  (fe_side),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  always_comb begin
    out_d = dv_side.pre;
    if (dv_side.mode == rac_pkg::MODE_STRAIGHT) begin
      out_d[0] = dv_side.alpha;
      for (int c = 0; c < rac_pkg::COLOR_N; c++) begin
        // zero coverage: drop the color
        out_d[c+1] = dv_side.den_zero ? '0 : dv_quo[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_q[0];
  assign out_r_o     = out_q[1];
  assign out_g_o     = out_q[2];
  assign out_b_o     = out_q[3];

endmodule

/* tb/sv/tb_rgba_alpha_compositor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgba_alpha_compositor
// Self-checking bench for the RGBA compositor. A short table of directed
// pixels covers channel extremes, every blend mode, zero coverage in straight
// over and transparent foreground in replace-where-opaque. Random pixels
// follow, in phases that switch the blend mode while the pipeline is empty.
// Each request is predicted at acceptance and results are checked in order.
// ----------------------------------------------------------------------------
module tb_rgba_alpha_compositor;

  typedef struct packed {
    rac_pkg::ch_t a;
    rac_pkg::ch_t r;
    rac_pkg::ch_t g;
    rac_pkg::ch_t b;
  } rgba_t;

  typedef struct packed {
    rac_pkg::blend_mode_e mode;
    logic                 typed;
    rgba_t                back;
    rgba_t                front;
    rgba_t                want;
  } pix_row_t;

  localparam int DIR_N      = 20;
  localparam int PHASE_N    = 8;
  localparam int PHASE_LEN  = 100;
  localparam int WDOG_LIMIT = 1000;
  localparam int TAIL_CYC   = 24;

  // directed rows: typed ones carry the expected pixel, others use the predictor
  localparam pix_row_t DIR_ROWS [DIR_N] = '{
    '{rac_pkg::MODE_PREMUL,         1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
    '{rac_pkg::MODE_PREMUL,         1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{rac_pkg::MODE_PREMUL,         1'b1, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF},
    '{rac_pkg::MODE_PREMUL,         1'b1, 32'hFF804020, 32'h00FFFFFF, 32'hFFFFFFFF},
    '{rac_pkg::MODE_PREMUL,         1'b0, 32'hC8643219, 32'h80402010, 32'h00000000},
    '{rac_pkg::MODE_PREMUL,         1'b0, 32'h7F7F7F7F, 32'h01010101, 32'h00000000},
    '{rac_pkg::MODE_STRAIGHT,       1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
    '{rac_pkg::MODE_STRAIGHT,       1'b1, 32'h00FFFFFF, 32'h00FFFFFF, 32'h00000000},
    '{rac_pkg::MODE_STRAIGHT,       1'b1, 32'hFF102030, 32'h00C0C0C0, 32'hFF102030},
    '{rac_pkg::MODE_STRAIGHT,       1'b1, 32'h80FFFFFF, 32'hFF0A141E, 32'hFF0A141E},
    '{rac_pkg::MODE_STRAIGHT,       1'b0, 32'h80C04020, 32'h40FF8000, 32'h00000000},
    '{rac_pkg::MODE_STRAIGHT,       1'b0, 32'h01FFFFFF, 32'hFE000000, 32'h00000000},
    '{rac_pkg::MODE_STRAIGHT,       1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{rac_pkg::MODE_REPLACE,        1'b1, 32'hFFFFFFFF, 32'h00123456, 32'h00123456},
    '{rac_pkg::MODE_REPLACE,        1'b1, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{rac_pkg::MODE_REPLACE_OPAQUE, 1'b1, 32'h11223344, 32'h00FFFFFF, 32'h11223344},
    '{rac_pkg::MODE_REPLACE_OPAQUE, 1'b1, 32'h11223344, 32'h01AABBCC, 32'h01AABBCC},
    '{rac_pkg::MODE_REPLACE_OPAQUE, 1'b1, 32'hFFFFFFFF, 32'hFF000000, 32'hFF000000},
    '{rac_pkg::MODE_REPLACE_OPAQUE, 1'b1, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF},
    '{rac_pkg::MODE_PREMUL,         1'b0, 32'h80808080, 32'h80808080, 32'h00000000}
  };

  localparam rac_pkg::blend_mode_e PHASE_MODES [PHASE_N] = '{
    rac_pkg::MODE_STRAIGHT, rac_pkg::MODE_REPLACE_OPAQUE, rac_pkg::MODE_PREMUL,
    rac_pkg::MODE_REPLACE, rac_pkg::MODE_STRAIGHT, rac_pkg::MODE_PREMUL,
    rac_pkg::MODE_REPLACE_OPAQUE, rac_pkg::MODE_REPLACE
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  logic [7:0] back_a_i    = '0;
  logic [7:0] back_r_i    = '0;
  logic [7:0] back_g_i    = '0;
  logic [7:0] back_b_i    = '0;
  logic [7:0] front_a_i   = '0;
  logic [7:0] front_r_i   = '0;
  logic [7:0] front_g_i   = '0;
  logic [7:0] front_b_i   = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i  = '0;
  logic       out_valid_o;
  logic [7:0] out_a_o;
  logic [7:0] out_r_o;
  logic [7:0] out_g_o;
  logic [7:0] out_b_o;

  rgba_t                blended_q [$];
  rac_pkg::blend_mode_e mode_q        = rac_pkg::MODE_PREMUL;
  logic                 no_gaps       = 1'b0;
  int                   mismatch_cnt  = 0;
  int                   pixels_sent   = 0;
  int                   results_seen  = 0;
  int                   cfg_writes    = 0;
  int                   idle_cycles   = 0;

  rgba_alpha_compositor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .back_a_i    (back_a_i),
    .back_r_i    (back_r_i),
    .back_g_i    (back_g_i),
    .back_b_i    (back_b_i),
    .front_a_i   (front_a_i),
    .front_r_i   (front_r_i),
    .front_g_i   (front_g_i),
    .front_b_i   (front_b_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_a_o     (out_a_o),
    .out_r_o     (out_r_o),
    .out_g_o     (out_g_o),
    .out_b_o     (out_b_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  function automatic rac_pkg::ch_t clip8(input int unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // blended pixel for one background/foreground pair under a given mode
  function automatic rgba_t blend_pixel(input rac_pkg::blend_mode_e m, input rgba_t bk,
                                        input rgba_t fr);
    int unsigned  bv [4];
    int unsigned  fv [4];
    rac_pkg::ch_t rv [4];
    int unsigned  inv;
    int unsigned  cov_den;
    bv = '{bk.a, bk.r, bk.g, bk.b};
    fv = '{fr.a, fr.r, fr.g, fr.b};
    inv = 255 - fv[0];
    cov_den = fv[0] * 255 + bv[0] * inv;
    for (int k = 0; k < 4; k++) begin
      case (m)
        rac_pkg::MODE_PREMUL: begin
          rv[k] = clip8(fv[k] + (bv[k] * inv) / 255);
        end
        rac_pkg::MODE_STRAIGHT: begin
          if (k == 0) rv[k] = clip8(cov_den / 255);
          else if (cov_den == 0) rv[k] = '0;
          else rv[k] = clip8((fv[k] * fv[0] * 255 + bv[k] * bv[0] * inv) / cov_den);
        end
        rac_pkg::MODE_REPLACE: begin
          rv[k] = fv[k][7:0];
        end
        default: begin
          rv[k] = (fv[0] != 0) ? fv[k][7:0] : bv[k][7:0];
        end
      endcase
    end
    return '{rv[0], rv[1], rv[2], rv[3]};
  endfunction

  // favor the channel extremes, otherwise uniform
  function automatic rac_pkg::ch_t rand_ch();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return rac_pkg::ch_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgba_t rand_pixel(input rac_pkg::blend_mode_e m);
    rgba_t p;
    p = '{rand_ch(), rand_ch(), rand_ch(), rand_ch()};
    // mostly well-formed premultiplied pixels: colors not above alpha
    if (m == rac_pkg::MODE_PREMUL && $urandom_range(0, 3) != 0) begin
      p.r = rac_pkg::ch_t'($urandom_range(0, p.a));
      p.g = rac_pkg::ch_t'($urandom_range(0, p.a));
      p.b = rac_pkg::ch_t'($urandom_range(0, p.a));
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic send_pixel(input rgba_t bk, input rgba_t fr, input rgba_t want);
    int gap;
    start <= 1'b1;
    {back_a_i, back_r_i, back_g_i, back_b_i} <= bk;
    {front_a_i, front_r_i, front_g_i, front_b_i} <= fr;
    do @(posedge clk_i); while (busy);
    blended_q.push_back(want);
    pixels_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(input rac_pkg::blend_mode_e m);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
    cfg_writes++;
  endtask

  task automatic check_ch(input string name, input rac_pkg::ch_t want,
                          input rac_pkg::ch_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result checker: the strobe cannot be stalled, sample every edge
  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni && out_valid_o === 1'b1) begin
      results_seen++;
      if (blended_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                 $time, out_a_o, out_r_o, out_g_o, out_b_o);
        mismatch_cnt++;
      end else begin
        want = blended_q.pop_front();
        check_ch("out_a", want.a, out_a_o);
        check_ch("out_r", want.r, out_r_o);
        check_ch("out_g", want.g, out_g_o);
        check_ch("out_b", want.b, out_b_o);
      end
    end
  end

  // watchdog: count edges without any handshake or result
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o === 1'b1 || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, blended_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pix_row_t row;
    rgba_t    bk;
    rgba_t    fr;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, first rows run on the reset mode
    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.mode != mode_q) set_mode(row.mode);
      send_pixel(row.back, row.front,
                 row.typed ? row.want : blend_pixel(mode_q, row.back, row.front));
    end

    // random phases, one blend mode each
    for (int ph = 0; ph < PHASE_N; ph++) begin
      set_mode(PHASE_MODES[ph]);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // halfway through odd phases, hold the sender until the pipeline has emptied
        if (n == PHASE_LEN / 2 && ph[0]) drain_results();
        bk = rand_pixel(mode_q);
        fr = rand_pixel(mode_q);
        send_pixel(bk, fr, blend_pixel(mode_q, bk, fr));
      end
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("Covered %0d pixels over %0d mode writes: all four blends, channel extremes,",
             pixels_sent, cfg_writes);
    $display("zero coverage and transparent foreground; %0d results checked, %0d mismatches",
             results_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && blended_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
